// ===== rtl/sha1_pkg.sv =====
// Package for the SHA-1 hash engine: constants, command and status types.
// Used by every module of the engine and by the testbench.
`default_nettype none
package sha1_pkg;
  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  typedef enum logic [1:0] {
    FILL_DATA = 2'd0,
    FILL_PAD  = 2'd1,
    FILL_ZERO = 2'd2,
    FILL_LEN  = 2'd3
  } fill_sel_t;

  typedef struct packed {
    logic      wr_byte;
    fill_sel_t fill_sel;
    logic      cnt_inc;
    logic      cnt_clr;
    logic      comp_start;
    logic      hash_init;
  } sha1_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       comp_busy;
    logic       comp_done;
  } sha1_sts_t;
endpackage
`default_nettype wire

// ===== rtl/sha1_if.sv =====
// Valid/ready channel interfaces for the SHA-1 engine's input and digest.
// Depends on nothing beyond the language.
`default_nettype none
interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last;
  modport source (output valid, output data_byte, output byte_valid, output last,
                  input ready);
  modport sink (input valid, input data_byte, input byte_valid, input last,
                output ready);
endinterface

interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_high;
  logic [63:0] digest_mid;
  logic [31:0] digest_low;
  modport source (output valid, output digest_high, output digest_mid,
                  output digest_low, input ready);
  modport sink (input valid, input digest_high, input digest_mid,
                input digest_low, output ready);
endinterface
`default_nettype wire

// ===== rtl/sha1_datapath.sv =====
// Datapath of the SHA-1 engine: block buffer, byte count, message schedule
// and one-round-per-cycle compression. Depends on sha1_pkg.
`default_nettype none
module sha1_datapath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire sha1_pkg::sha1_cmd_t cmd,
  input  wire logic [7:0]          data_byte,
  output sha1_pkg::sha1_sts_t      sts,
  output logic [159:0]             digest
);
  logic [31:0] blk_r [16];
  logic [60:0] cnt_r;
  logic [5:0]  pos_r;
  logic [31:0] h_r [5];
  logic [31:0] w_r [16];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [6:0]  rnd_r;
  logic        busy_r;
  logic        load_r;
  logic        done_r;
  logic [7:0]  fill_byte;
  logic [5:0]  fill;
  logic [63:0] bits;
  logic [31:0] wt, f, k, tmp, wnew;

  assign fill = pos_r;
  assign bits = {cnt_r, 3'b000};

  always_comb begin
    case (cmd.fill_sel)
      sha1_pkg::FILL_DATA: fill_byte = data_byte;
      sha1_pkg::FILL_PAD:  fill_byte = sha1_pkg::PAD_BYTE;
      sha1_pkg::FILL_ZERO: fill_byte = 8'h00;
      default:             fill_byte = bits[{~fill[2:0], 3'b000} +: 8];
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_byte) begin
      blk_r[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= fill_byte;
    end
  end

  // Schedule: the first 16 rounds shift block words in, later rounds expand.
  assign wnew = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
  assign wt = (rnd_r < 7'd16) ? w_r[0] : {wnew[30:0], wnew[31]};

  always_comb begin
    if (rnd_r < 7'd20) begin
      f = d_r ^ (b_r & (c_r ^ d_r));
      k = sha1_pkg::K0;
    end else if (rnd_r < 7'd40) begin
      f = b_r ^ c_r ^ d_r;
      k = sha1_pkg::K1;
    end else if (rnd_r < 7'd60) begin
      f = (b_r & c_r) | (d_r & (b_r | c_r));
      k = sha1_pkg::K2;
    end else begin
      f = b_r ^ c_r ^ d_r;
      k = sha1_pkg::K3;
    end
  end
  assign tmp = {a_r[26:0], a_r[31:27]} + f + e_r + k + wt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      pos_r  <= '0;
      busy_r <= 1'b0;
      load_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= '0;
      h_r[0] <= sha1_pkg::H0;
      h_r[1] <= sha1_pkg::H1;
      h_r[2] <= sha1_pkg::H2;
      h_r[3] <= sha1_pkg::H3;
      h_r[4] <= sha1_pkg::H4;
    end else begin
      done_r <= 1'b0;
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + 61'd1;
      end
      if (cmd.cnt_clr) begin
        pos_r <= '0;
      end else if (cmd.wr_byte) begin
        pos_r <= pos_r + 6'd1;
      end
      if (cmd.hash_init) begin
        h_r[0] <= sha1_pkg::H0;
        h_r[1] <= sha1_pkg::H1;
        h_r[2] <= sha1_pkg::H2;
        h_r[3] <= sha1_pkg::H3;
        h_r[4] <= sha1_pkg::H4;
      end
      if (cmd.comp_start) begin
        load_r <= 1'b1;
        busy_r <= 1'b1;
      end else if (load_r) begin
        load_r <= 1'b0;
        rnd_r  <= '0;
        for (int i = 0; i < 16; i++) begin
          w_r[i] <= blk_r[i];
        end
        a_r <= h_r[0];
        b_r <= h_r[1];
        c_r <= h_r[2];
        d_r <= h_r[3];
        e_r <= h_r[4];
      end else if (busy_r) begin
        if (rnd_r == 7'd80) begin
          h_r[0] <= h_r[0] + a_r;
          h_r[1] <= h_r[1] + b_r;
          h_r[2] <= h_r[2] + c_r;
          h_r[3] <= h_r[3] + d_r;
          h_r[4] <= h_r[4] + e_r;
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          for (int i = 0; i < 15; i++) begin
            w_r[i] <= w_r[i+1];
          end
          w_r[15] <= wt;
          e_r <= d_r;
          d_r <= c_r;
          c_r <= {b_r[1:0], b_r[31:2]};
          b_r <= a_r;
          a_r <= tmp;
          rnd_r <= rnd_r + 7'd1;
        end
      end
    end
  end

  assign sts.fill = fill;
  assign sts.comp_busy = busy_r | load_r;
  assign sts.comp_done = done_r;
  assign digest = {h_r[0], h_r[1], h_r[2], h_r[3], h_r[4]};

  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rnd_r <= 7'd80) else $error("round counter beyond 80");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("done held longer than a cycle");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.comp_start |-> !(busy_r || load_r)) else $error("start while busy");
endmodule
`default_nettype wire

// ===== rtl/sha1_ctrl.sv =====
// Controller of the SHA-1 engine: handshake, padding sequence and digest
// hand-off. Depends on sha1_pkg.
`default_nettype none
module sha1_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_byte_valid,
  input  wire logic                in_last,
  output logic                     in_ready,
  input  wire logic                out_ready,
  output logic                     out_valid,
  output logic                     out_load,
  input  wire sha1_pkg::sha1_sts_t sts,
  output sha1_pkg::sha1_cmd_t      cmd
);
  typedef enum logic [2:0] {
    S_IDLE, S_BLK, S_PAD, S_ZERO, S_FIN1, S_LEN, S_FIN2, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   fin_r, fin_nxt;
  logic   acc;

  assign in_ready  = (state_r == S_IDLE) && !sts.comp_busy;
  assign acc       = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    fin_nxt       = fin_r;
    out_load      = 1'b0;
    cmd           = '0;
    cmd.fill_sel  = sha1_pkg::FILL_DATA;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          fin_nxt = in_last;
          if (in_byte_valid) begin
            cmd.wr_byte = 1'b1;
            cmd.cnt_inc = 1'b1;
            if (sts.fill == 6'd63) begin
              cmd.comp_start = 1'b1;
              state_nxt = S_BLK;
            end else if (in_last) begin
              state_nxt = S_PAD;
            end
          end else if (in_last) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_BLK: begin
        if (sts.comp_done) begin
          state_nxt = fin_r ? S_PAD : S_IDLE;
        end
      end
      S_PAD: begin
        cmd.wr_byte  = 1'b1;
        cmd.fill_sel = sha1_pkg::FILL_PAD;
        if (sts.fill == 6'd63) begin
          cmd.comp_start = 1'b1;
          state_nxt = S_FIN1;
        end else if (sts.fill >= 6'd56) begin
          state_nxt = S_ZERO;
        end else begin
          state_nxt = S_LEN;
        end
      end
      S_ZERO: begin
        // Pad-out of a block whose length field does not fit.
        cmd.wr_byte  = 1'b1;
        cmd.fill_sel = sha1_pkg::FILL_ZERO;
        if (sts.fill == 6'd63) begin
          cmd.comp_start = 1'b1;
          state_nxt = S_FIN1;
        end
      end
      S_FIN1: begin
        if (sts.comp_done) begin
          state_nxt = S_LEN;
        end
      end
      S_LEN: begin
        cmd.wr_byte = 1'b1;
        if (sts.fill >= 6'd56) begin
          cmd.fill_sel = sha1_pkg::FILL_LEN;
        end else begin
          cmd.fill_sel = sha1_pkg::FILL_ZERO;
        end
        if (sts.fill == 6'd63) begin
          cmd.comp_start = 1'b1;
          state_nxt = S_FIN2;
        end
      end
      S_FIN2: begin
        if (sts.comp_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_nxt) begin
          out_load       = 1'b1;
          out_valid_nxt  = 1'b1;
          cmd.hash_init  = 1'b1;
          cmd.cnt_clr    = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      fin_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      fin_r       <= fin_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ready)) else $error("digest overwritten");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    sts.comp_busy |-> !in_ready) else $error("input taken during compression");
  a_start_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.comp_start |-> (sts.fill == 6'd63)) else $error("start on partial block");
endmodule
`default_nettype wire

// ===== rtl/sha1_hash_engine.sv =====
// SHA-1 engine: at most one byte per beat in, one 160-bit digest beat per message out.
// Top level; depends on sha1_pkg, sha1_if, sha1_ctrl and sha1_datapath.
//
// A byte beat is taken only while the controller is idle and no compression
// runs; the 64th byte of a block starts a compression (load, 80 rounds, final
// add) in the single round unit, and on its done the controller returns to
// idle, so no beat is taken while a block is compressed. After the last beat
// the controller writes the padding bytes and runs one or two compressions
// and a hand-off step before the digest beat appears; the digest sits in an
// output register so the next message may start while it waits, and a
// following digest is held back until it has been taken.
`default_nettype none
module sha1_hash_engine (
  input  wire logic   clk,
  input  wire logic   rst_n,
  sha1_in_if.sink     in_ch,
  sha1_out_if.source  out_ch
);
  sha1_pkg::sha1_cmd_t cmd;
  sha1_pkg::sha1_sts_t sts;
  logic [159:0]        digest;
  logic [159:0]        out_r;
  logic                out_load;

  sha1_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_byte_valid (in_ch.byte_valid),
    .in_last       (in_ch.last),
    .in_ready      (in_ch.ready),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_load      (out_load),
    .sts           (sts),
    .cmd           (cmd)
  );

  sha1_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .data_byte (in_ch.data_byte),
    .sts       (sts),
    .digest    (digest)
  );

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= digest;
    end
  end

  assign out_ch.digest_high = out_r[159:96];
  assign out_ch.digest_mid  = out_r[95:32];
  assign out_ch.digest_low  = out_r[31:0];
endmodule
`default_nettype wire

// ===== sim/sha1_tb_if.sv =====
`timescale 1ns / 100ps
// Testbench-side note: the channel interfaces live in rtl/sha1_if.sv and are
// reused here unchanged; this file only holds the digest record type.
package sha1_tb_pkg;
  typedef struct packed {
    logic [63:0] digest_high;
    logic [63:0] digest_mid;
    logic [31:0] digest_low;
  } digest_t;
endpackage

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Testbench for sha1_hash_engine: drives byte beats with random gaps, predicts
// each digest with its own SHA-1 and checks every digest beat in order.
// Depends on sha1_pkg, sha1_if and sha1_tb_pkg.
module tb;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 400;

  typedef struct {
    logic [7:0]           data_byte;
    logic                 byte_valid;
    logic                 last;
    logic                 has_digest;
    sha1_tb_pkg::digest_t digest;
  } stim_row_t;

  logic clk;
  logic rst_n;
  sha1_in_if  in_ch ();
  sha1_out_if out_ch ();

  sha1_hash_engine u_top (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  logic [31:0]          chain_words [5];
  logic [7:0]           msg_block [64];
  logic [60:0]          msg_bytes;
  sha1_tb_pkg::digest_t digest_queue [$];
  int                   error_count;
  int                   idle_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void reset_chain();
    chain_words[0] = sha1_pkg::H0;
    chain_words[1] = sha1_pkg::H1;
    chain_words[2] = sha1_pkg::H2;
    chain_words[3] = sha1_pkg::H3;
    chain_words[4] = sha1_pkg::H4;
    msg_bytes = '0;
  endfunction

  function automatic void compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, t_sum;
    for (int t = 0; t < 16; t++)
      w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    a = chain_words[0]; b = chain_words[1]; c = chain_words[2];
    d = chain_words[3]; e = chain_words[4];
    for (int t = 0; t < 80; t++) begin
      if (t >= 16)
        w[t%16] = rotl(w[(t-3)%16] ^ w[(t-8)%16] ^ w[(t-14)%16] ^ w[t%16], 1);
      if (t < 20) begin
        f = d ^ (b & (c ^ d)); k = sha1_pkg::K0;
      end else if (t < 40) begin
        f = b ^ c ^ d; k = sha1_pkg::K1;
      end else if (t < 60) begin
        f = (b & c) | (d & (b | c)); k = sha1_pkg::K2;
      end else begin
        f = b ^ c ^ d; k = sha1_pkg::K3;
      end
      t_sum = rotl(a, 5) + f + e + k + w[t%16];
      e = d; d = c; c = rotl(b, 30); b = a; a = t_sum;
    end
    chain_words[0] += a; chain_words[1] += b; chain_words[2] += c;
    chain_words[3] += d; chain_words[4] += e;
  endfunction

  // Returns 1 and fills dig when the beat closes a message.
  function automatic bit hash_beat(input logic [7:0] data_byte, input logic byte_valid,
                                   input logic last, output sha1_tb_pkg::digest_t dig);
    int fill;
    logic [63:0] bit_len;
    dig = '0;
    if (byte_valid) begin
      msg_block[msg_bytes[5:0]] = data_byte;
      msg_bytes = msg_bytes + 61'd1;
      if (msg_bytes[5:0] == 6'd0) compress();
    end
    if (!last) return 0;
    fill = int'(msg_bytes[5:0]);
    msg_block[fill] = sha1_pkg::PAD_BYTE;
    for (int i = fill + 1; i < 64; i++) msg_block[i] = 8'h00;
    if (fill >= 56) begin
      compress();
      for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
    end
    bit_len = {msg_bytes, 3'b000};
    for (int i = 0; i < 8; i++) msg_block[56+i] = bit_len[63-8*i -: 8];
    compress();
    dig = {chain_words[0], chain_words[1], chain_words[2], chain_words[3], chain_words[4]};
    reset_chain();
    return 1;
  endfunction

  task automatic send_beat(input logic [7:0] data_byte, input logic byte_valid,
                           input logic last, input bit typed,
                           input sha1_tb_pkg::digest_t typed_dig);
    sha1_tb_pkg::digest_t dig;
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= data_byte;
    in_ch.byte_valid <= byte_valid;
    in_ch.last       <= last;
    do @(posedge clk); while (!in_ch.ready);
    if (hash_beat(data_byte, byte_valid, last, dig)) begin
      if (typed && dig != typed_dig)
        $display("%0t predictor disagrees with typed digest: expected %h actual %h",
                 $time, typed_dig, dig);
      digest_queue.push_back(typed ? typed_dig : dig);
    end
  endtask

  task automatic send_message(input int len, input bit empty_tail);
    for (int i = 0; i < len; i++)
      send_beat(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !empty_tail, 0, '0);
    if (empty_tail || len == 0) send_beat(8'h00, 1'b0, 1'b1, 0, '0);
  endtask

  // Sink side: random stalls, then check each digest beat against the oldest prediction.
  initial begin
    sha1_tb_pkg::digest_t got;
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got = {out_ch.digest_high, out_ch.digest_mid, out_ch.digest_low};
      if (digest_queue.size() == 0) begin
        $display("%0t unexpected digest beat: expected none actual %h", $time, got);
        error_count++;
      end else if (got != digest_queue[0]) begin
        $display("%0t digest mismatch: expected %h actual %h", $time, digest_queue[0], got);
        error_count++;
        void'(digest_queue.pop_front());
      end else begin
        void'(digest_queue.pop_front());
      end
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t table_rows [$];
    int boundary_lens [7];
    int count;
    error_count = 0;
    boundary_lens = '{55, 56, 63, 64, 119, 120, 128};
    reset_chain();
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.data_byte  <= 8'h00;
    in_ch.byte_valid <= 1'b0;
    in_ch.last       <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows: empty message, "abc", a beat with no flags, byte extremes.
    table_rows.push_back('{8'h00, 1'b0, 1'b1, 1'b1,
      {64'hda39a3ee5e6b4b0d, 64'h3255bfef95601890, 32'hafd80709}});
    table_rows.push_back('{8'h61, 1'b1, 1'b0, 1'b0, '0});
    table_rows.push_back('{8'h00, 1'b0, 1'b0, 1'b0, '0});
    table_rows.push_back('{8'h62, 1'b1, 1'b0, 1'b0, '0});
    table_rows.push_back('{8'h63, 1'b1, 1'b1, 1'b1,
      {64'ha9993e364706816a, 64'hba3e25717850c26c, 32'h9cd0d89d}});
    table_rows.push_back('{8'h00, 1'b1, 1'b0, 1'b0, '0});
    table_rows.push_back('{8'hff, 1'b1, 1'b0, 1'b0, '0});
    table_rows.push_back('{8'h00, 1'b0, 1'b1, 1'b0, '0});
    table_rows.push_back('{8'hff, 1'b1, 1'b1, 1'b0, '0});
    foreach (table_rows[i])
      send_beat(table_rows[i].data_byte, table_rows[i].byte_valid, table_rows[i].last,
                table_rows[i].has_digest, table_rows[i].digest);

    // Lengths around the padding boundaries, each ended both ways.
    foreach (boundary_lens[i]) begin
      send_message(boundary_lens[i], 1'b0);
      send_message(boundary_lens[i], 1'b1);
    end

    count = 0;
    while (count < 300) begin
      int len;
      len = $urandom_range(0, 7) == 0 ? $urandom_range(50, 140) : $urandom_range(0, 20);
      if ($urandom_range(0, 9) == 0) begin
        send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0, 0, '0);
      end
      send_message(len, 1'($urandom_range(0, 1)));
      count += len + 1;
    end
    in_ch.valid <= 1'b0;

    while (digest_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && digest_queue.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end
endmodule

// ===== sha1_hash_engine.f =====
rtl/sha1_pkg.sv
rtl/sha1_if.sv
rtl/sha1_datapath.sv
rtl/sha1_ctrl.sv
rtl/sha1_hash_engine.sv
sim/sha1_tb_if.sv
sim/tb.sv
